// ----- rtl/opcode_and_pair_profiler_unit_defines.svh -----
// Assertion macros for the opcode and pair profiler.
// Included by the top level only; expects clk and rst_n in scope.
`ifndef OPCODE_AND_PAIR_PROFILER_UNIT_DEFINES_SVH
`define OPCODE_AND_PAIR_PROFILER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OPPROF_AST_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("opprof: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define OPPROF_AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("opprof: next-cycle check failed");

`endif

// ----- rtl/opprof_pkg.sv -----
// Shared types and defaults for the opcode and pair profiler.
// No dependencies; used by the top level.
package opprof_pkg;

  localparam int DEF_NUM_OPCODES = 128;
  localparam int DEF_COUNT_BITS  = 32;
  localparam int DEF_ADDR_BITS   = 32;

  localparam int OPCODE_W = 7;
  localparam int OUT_W    = 32;

  // Index order of the three stack tops.
  localparam int TOP_LOCAL = 0;
  localparam int TOP_HEAP  = 1;
  localparam int TOP_TRAIL = 2;
  localparam int NUM_TOPS  = 3;

  typedef enum logic [1:0] {
    FN_EXEC  = 2'd0,
    FN_START = 2'd1,
    FN_READ  = 2'd2
  } func_t;

endpackage

// ----- rtl/opprof_ram.sv -----
// Single write port, single read port memory with registered read data.
// Standalone; instantiated twice by the profiler top level.
module opprof_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read-before-write on a same-address collision; the caller forwards.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/opcode_and_pair_profiler_unit.sv -----
// Opcode and pair execution profiler.
// Input channel (in_valid / in_stall) carries one item per cycle while in_stall is low: an execute,
// a start, or a read. Execute bumps the total, the opcode count and the count
// of the pair (previous opcode, this opcode), and tracks stack-top extremes.
// Start clears both tables and the total and takes the current tops as
// baselines. A read returns one item on the out_ channel; execute and start
// return nothing.
// Throughput is one item per cycle while in_stall is low: both count tables are single-port-write
// memories with registered reads, updated read-modify-write in the cycle after
// acceptance, with forwarding from the write of the same edge.
// A read result is loaded into the output register from the update stage once
// the output register is empty or not stalled.
// While the receiver stalls with a result waiting, one more item is held in
// the update stage; a read there then stalls the input until the output frees.
// After reset, and after every start item, a clearing pass writes zero to
// every table entry, one pair entry per cycle; in_stall is high during the pass.
// Reset is synchronous, active low.
module opcode_and_pair_profiler_unit #(
  parameter int NUM_OPCODES = opprof_pkg::DEF_NUM_OPCODES,
  parameter int COUNT_BITS  = opprof_pkg::DEF_COUNT_BITS,
  parameter int ADDR_BITS   = opprof_pkg::DEF_ADDR_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [6:0]  in_opcode,
  input  logic [6:0]  in_second_opcode,
  input  logic [31:0] in_local_addr,
  input  logic [31:0] in_heap_addr,
  input  logic [31:0] in_trail_addr,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_total_count,
  output logic [31:0] out_opcode_count,
  output logic [31:0] out_pair_count,
  output logic [31:0] out_local_range,
  output logic [31:0] out_heap_range,
  output logic [31:0] out_trail_range
);

  `include "opcode_and_pair_profiler_unit_defines.svh"

  localparam int OP_W   = $clog2(NUM_OPCODES);
  localparam int PAIRS  = NUM_OPCODES * NUM_OPCODES;
  localparam int PAIR_W = $clog2(PAIRS);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  opprof_pkg::func_t in_fn;
  logic in_acc;
  logic op_ok_in, op2_ok_in, last_ok;
  logic [OP_W-1:0]   op_idx_in, op2_idx_in, last_idx;
  logic [OP_W-1:0]   op_ra;
  logic [PAIR_W-1:0] pr_ra;
  logic [ADDR_BITS-1:0] addr_in [opprof_pkg::NUM_TOPS];

  // Scalar state, updated at acceptance and during the clearing pass.
  logic                  clearing_r;
  logic [PAIR_W-1:0]     clr_cnt_r;
  logic [COUNT_BITS-1:0] total_r;
  logic [6:0]            last_opcode_r;
  logic [ADDR_BITS-1:0]  cur_r  [opprof_pkg::NUM_TOPS];
  logic [ADDR_BITS-1:0]  base_r [opprof_pkg::NUM_TOPS];
  logic [ADDR_BITS-1:0]  ext_r  [opprof_pkg::NUM_TOPS];

  // Update stage.
  logic                  s1_valid_r;
  logic                  s1_is_read_r;
  logic                  s1_op_ok_r, s1_pair_ok_r;
  logic [OP_W-1:0]       s1_op_idx_r;
  logic [PAIR_W-1:0]     s1_pair_idx_r;
  logic                  s1_op_fwd_r, s1_pr_fwd_r;
  logic [COUNT_BITS-1:0] s1_op_fd_r, s1_pr_fd_r;

  logic [COUNT_BITS-1:0] op_rd, pr_rd, op_val, pr_val, op_inc, pr_inc;
  logic                  op_we, pr_we;
  logic [OP_W-1:0]       op_wa;
  logic [PAIR_W-1:0]     pr_wa;
  logic [COUNT_BITS-1:0] op_wd, pr_wd;

  logic out_valid_r, out_can_load, out_ld;
  logic [ADDR_BITS-1:0] top_gap [opprof_pkg::NUM_TOPS];

  assign in_fn  = opprof_pkg::func_t'(in_func);
  assign in_acc = in_valid && !in_stall;

  assign op_ok_in   = 32'(in_opcode) < NUM_OPCODES;
  assign op2_ok_in  = 32'(in_second_opcode) < NUM_OPCODES;
  assign last_ok    = 32'(last_opcode_r) < NUM_OPCODES;
  assign op_idx_in  = OP_W'(in_opcode);
  assign op2_idx_in = OP_W'(in_second_opcode);
  assign last_idx   = OP_W'(last_opcode_r);

  assign addr_in[opprof_pkg::TOP_LOCAL] = ADDR_BITS'(in_local_addr);
  assign addr_in[opprof_pkg::TOP_HEAP]  = ADDR_BITS'(in_heap_addr);
  assign addr_in[opprof_pkg::TOP_TRAIL] = ADDR_BITS'(in_trail_addr);

  // A read queries (opcode, second); an execute bumps (previous, opcode).
  assign op_ra = op_idx_in;
  always_comb begin
    if (in_fn == opprof_pkg::FN_READ) begin
      pr_ra = PAIR_W'(op_idx_in) * PAIR_W'(NUM_OPCODES) + PAIR_W'(op2_idx_in);
    end else begin
      pr_ra = PAIR_W'(last_idx) * PAIR_W'(NUM_OPCODES) + PAIR_W'(op_idx_in);
    end
  end

  assign out_can_load = !out_valid_r || !out_stall;
  assign out_ld       = s1_valid_r && s1_is_read_r && out_can_load;
  assign in_stall     = clearing_r || (s1_valid_r && s1_is_read_r && !out_can_load);

  // Counts seen by the update stage, with the write of the read edge forwarded.
  assign op_val = s1_op_fwd_r ? s1_op_fd_r : op_rd;
  assign pr_val = s1_pr_fwd_r ? s1_pr_fd_r : pr_rd;
  assign op_inc = (op_val == COUNT_MAX) ? op_val : op_val + 1'b1;
  assign pr_inc = (pr_val == COUNT_MAX) ? pr_val : pr_val + 1'b1;

  always_comb begin
    op_we = 1'b0;
    op_wa = s1_op_idx_r;
    op_wd = op_inc;
    pr_we = 1'b0;
    pr_wa = s1_pair_idx_r;
    pr_wd = pr_inc;
    if (clearing_r) begin
      op_we = clr_cnt_r < PAIR_W'(NUM_OPCODES);
      op_wa = clr_cnt_r[OP_W-1:0];
      op_wd = '0;
      pr_we = 1'b1;
      pr_wa = clr_cnt_r;
      pr_wd = '0;
    end else if (s1_valid_r && !s1_is_read_r) begin
      op_we = s1_op_ok_r;
      pr_we = s1_pair_ok_r;
    end
  end

  opprof_ram #(
    .DEPTH (NUM_OPCODES),
    .WIDTH (COUNT_BITS)
  ) u_op_ram (
    .clk     (clk),
    .wr_en   (op_we),
    .wr_addr (op_wa),
    .wr_data (op_wd),
    .rd_en   (in_acc),
    .rd_addr (op_ra),
    .rd_data (op_rd)
  );

  opprof_ram #(
    .DEPTH (PAIRS),
    .WIDTH (COUNT_BITS)
  ) u_pair_ram (
    .clk     (clk),
    .wr_en   (pr_we),
    .wr_addr (pr_wa),
    .wr_data (pr_wd),
    .rd_en   (in_acc),
    .rd_addr (pr_ra),
    .rd_data (pr_rd)
  );

  always_comb begin
    for (int k = 0; k < opprof_pkg::NUM_TOPS; k++) begin
      top_gap[k] = (ext_r[k] >= base_r[k]) ? ext_r[k] - base_r[k] : base_r[k] - ext_r[k];
    end
  end

  // Control and architectural state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r    <= 1'b1;
      clr_cnt_r     <= '0;
      total_r       <= '0;
      last_opcode_r <= '0;
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      for (int k = 0; k < opprof_pkg::NUM_TOPS; k++) begin
        cur_r[k]  <= '0;
        base_r[k] <= '0;
        ext_r[k]  <= '0;
      end
    end else begin
      if (clearing_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == PAIR_W'(PAIRS - 1)) begin
          clearing_r <= 1'b0;
        end
      end

      if (out_ld) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (in_acc) begin
        s1_valid_r <= (in_fn == opprof_pkg::FN_EXEC) || (in_fn == opprof_pkg::FN_READ);
      end else if (s1_valid_r && (!s1_is_read_r || out_can_load)) begin
        s1_valid_r <= 1'b0;
      end

      if (in_acc) begin
        case (in_fn)
          opprof_pkg::FN_EXEC: begin
            total_r       <= (total_r == COUNT_MAX) ? total_r : total_r + 1'b1;
            last_opcode_r <= in_opcode;
            for (int k = 0; k < opprof_pkg::NUM_TOPS; k++) begin
              cur_r[k] <= addr_in[k];
            end
            if (addr_in[opprof_pkg::TOP_LOCAL] < ext_r[opprof_pkg::TOP_LOCAL]) begin
              ext_r[opprof_pkg::TOP_LOCAL] <= addr_in[opprof_pkg::TOP_LOCAL];
            end
            if (addr_in[opprof_pkg::TOP_HEAP] > ext_r[opprof_pkg::TOP_HEAP]) begin
              ext_r[opprof_pkg::TOP_HEAP] <= addr_in[opprof_pkg::TOP_HEAP];
            end
            if (addr_in[opprof_pkg::TOP_TRAIL] < ext_r[opprof_pkg::TOP_TRAIL]) begin
              ext_r[opprof_pkg::TOP_TRAIL] <= addr_in[opprof_pkg::TOP_TRAIL];
            end
          end
          opprof_pkg::FN_START: begin
            total_r    <= '0;
            clearing_r <= 1'b1;
            clr_cnt_r  <= '0;
            for (int k = 0; k < opprof_pkg::NUM_TOPS; k++) begin
              base_r[k] <= cur_r[k];
              ext_r[k]  <= cur_r[k];
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Update-stage payload and output payload.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_is_read_r  <= in_fn == opprof_pkg::FN_READ;
      s1_op_ok_r    <= op_ok_in;
      s1_pair_ok_r  <= (in_fn == opprof_pkg::FN_READ) ? (op_ok_in && op2_ok_in)
                                                      : (op_ok_in && last_ok);
      s1_op_idx_r   <= op_ra;
      s1_pair_idx_r <= pr_ra;
      s1_op_fwd_r   <= op_we && (op_wa == op_ra);
      s1_pr_fwd_r   <= pr_we && (pr_wa == pr_ra);
      s1_op_fd_r    <= op_wd;
      s1_pr_fd_r    <= pr_wd;
    end
    if (out_ld) begin
      out_total_count  <= 32'(total_r);
      out_opcode_count <= s1_op_ok_r ? 32'(op_val) : '0;
      out_pair_count   <= s1_pair_ok_r ? 32'(pr_val) : '0;
      out_local_range  <= 32'(top_gap[opprof_pkg::TOP_LOCAL]);
      out_heap_range   <= 32'(top_gap[opprof_pkg::TOP_HEAP]);
      out_trail_range  <= 32'(top_gap[opprof_pkg::TOP_TRAIL]);
    end
  end

  assign out_valid = out_valid_r;

  `OPPROF_AST_IMP(a_clear_pipe_empty, clearing_r, !s1_valid_r)
  `OPPROF_AST_NXT(a_start_clears, in_acc && in_fn == opprof_pkg::FN_START, clearing_r && total_r == '0)
  `OPPROF_AST_NXT(a_total_no_drop, !(in_acc && in_fn == opprof_pkg::FN_START), total_r >= $past(total_r))

endmodule
